// ----- src/cfa_pkg.sv -----
// cfa_pkg: shared types and constants for the complex four-operation alu
// used by complex_four_op_alu and cfa_div_step; no dependencies
package cfa_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int THR_W         = 31;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } cfa_kind_t;

  // control that travels with every item down the pipeline
  typedef struct packed {
    logic valid;
    logic is_div;
    logic dz;
    logic ov;
    logic neg_re;
    logic neg_im;
    logic big_re;
    logic big_im;
  } cfa_ctl_t;

endpackage

// ----- src/complex_four_op_alu.sv -----
// complex_four_op_alu: pipelined complex add, subtract, multiply and divide
// depends on cfa_pkg and cfa_div_step
//
// usage:
//   an item (in_kind and the two complex operands) is accepted at a rising
//   edge with start high and busy low; busy is always low, so an item may
//   enter every cycle. each item gives one result on the out_ ports, marked
//   by out_valid for exactly one cycle, in input order.
//   the path is multiply, combine, magnitude and saturate, range check, one
//   stage per quotient bit of the divider, final saturate, then class and
//   output register. throughput is one item per cycle for every operation;
//   the divider chain sets the latency.
//   cfg_wr_en/cfg_wr_data write the zero threshold; write it only while no
//   item is in flight.
//   reset (rst_n low at an edge) empties the pipeline and sets the threshold
//   to 0.1 in the fixed-point format. the receiver cannot stall; every result
//   is shown for one cycle only.
module complex_four_op_alu #(
  parameter int WORD_BITS = cfa_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cfa_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_kind,
  input  logic signed [WORD_BITS-1:0]       in_a_real,
  input  logic signed [WORD_BITS-1:0]       in_a_imag,
  input  logic signed [WORD_BITS-1:0]       in_b_real,
  input  logic signed [WORD_BITS-1:0]       in_b_imag,
  input  logic                              cfg_wr_en,
  input  logic [cfa_pkg::THR_W-1:0]         cfg_wr_data,
  output logic                              out_valid,
  output logic signed [WORD_BITS-1:0]       out_res_real,
  output logic signed [WORD_BITS-1:0]       out_res_imag,
  output logic [1:0]                        out_result_class,
  output logic                              out_div_zero,
  output logic                              out_overflow
);
  import cfa_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2*W;
  localparam int XW = 2*W+1;
  localparam int SW = W+1;
  localparam int RW = 3*W+FRAC_BITS;
  localparam int CW = (W > THR_W) ? W : THR_W;
  localparam logic [THR_W-1:0] THR_RST =
    THR_W'(((longint'(1) << FRAC_BITS) + 5) / 10);
  localparam logic signed [XW-1:0] X_MAX = XW'((longint'(1) << (W-1)) - 1);
  localparam logic signed [XW-1:0] X_MIN = XW'(-(longint'(1) << (W-1)));
  localparam logic [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_w(input logic signed [XW-1:0] v);
    logic [W:0] r;
    if (v > X_MAX) begin
      r = {1'b1, W_MAX};
    end else if (v < X_MIN) begin
      r = {1'b1, W_MIN};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  logic [THR_W-1:0] thr_r;
  logic             acc;

  // stage 1: products and add/sub
  logic                  s1_vld_r;
  cfa_kind_t             s1_kind_r;
  logic signed [PW-1:0]  s1_p_rr_r, s1_p_ii_r, s1_p_ri_r, s1_p_ir_r;
  logic signed [PW-1:0]  s1_p_brr_r, s1_p_bii_r;
  logic signed [SW-1:0]  s1_s_re_r, s1_s_im_r;
  logic signed [SW-1:0]  s_re_nxt, s_im_nxt;

  // stage 2: combined sums
  logic                  s2_vld_r;
  cfa_kind_t             s2_kind_r;
  logic signed [XW-1:0]  s2_x_re_r, s2_x_im_r;
  logic [PW-1:0]         s2_den_r;
  logic signed [XW-1:0]  x_re_nxt, x_im_nxt;
  logic signed [PW-1:0]  den_sum;

  // stage 3: magnitudes or saturated results
  cfa_ctl_t              s3_ctl_r, s3_ctl_nxt;
  logic [PW-1:0]         s3_mag_re_r, s3_mag_im_r, mag_re_nxt, mag_im_nxt;
  logic [W-1:0]          s3_q_re_r, s3_q_im_r, q3_re_nxt, q3_im_nxt;
  logic [PW-1:0]         s3_den_r;
  logic signed [XW-1:0]  sh_re, sh_im, neg_x_re, neg_x_im;
  logic [W:0]            sat_re, sat_im;

  // stage 4: range check, divider input
  cfa_ctl_t              s4_ctl_r, s4_ctl_nxt;
  logic [RW-1:0]         s4_rem_re_r, s4_rem_im_r, rem_re_nxt, rem_im_nxt;
  logic [W-1:0]          s4_q_re_r, s4_q_im_r;
  logic [PW-1:0]         s4_den_r;
  logic [RW-1:0]         den_top;

  // divider chain
  cfa_ctl_t              dv_ctl    [0:W];
  logic [RW-1:0]         dv_rem_re [0:W];
  logic [RW-1:0]         dv_rem_im [0:W];
  logic [W-1:0]          dv_q_re   [0:W];
  logic [W-1:0]          dv_q_im   [0:W];
  logic [PW-1:0]         dv_den    [0:W];

  // final stage
  logic                  f1_vld_r, f1_dz_r, f1_ov_r;
  logic [W-1:0]          f1_re_r, f1_im_r, f_re_nxt, f_im_nxt;
  logic                  f_ov_nxt, sat_d_re, sat_d_im;
  logic [W-1:0]          neg_q_re, neg_q_im;
  logic [W-1:0]          mag_o_re, mag_o_im;
  logic [1:0]            cls_nxt;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RST;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // ---------------- stage 1
  always_comb begin
    if (cfa_kind_t'(in_kind) == KIND_SUB) begin
      s_re_nxt = SW'(in_a_real) - SW'(in_b_real);
      s_im_nxt = SW'(in_a_imag) - SW'(in_b_imag);
    end else begin
      s_re_nxt = SW'(in_a_real) + SW'(in_b_real);
      s_im_nxt = SW'(in_a_imag) + SW'(in_b_imag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r  <= cfa_kind_t'(in_kind);
    s1_p_rr_r  <= PW'(in_a_real) * PW'(in_b_real);
    s1_p_ii_r  <= PW'(in_a_imag) * PW'(in_b_imag);
    s1_p_ri_r  <= PW'(in_a_real) * PW'(in_b_imag);
    s1_p_ir_r  <= PW'(in_a_imag) * PW'(in_b_real);
    s1_p_brr_r <= PW'(in_b_real) * PW'(in_b_real);
    s1_p_bii_r <= PW'(in_b_imag) * PW'(in_b_imag);
    s1_s_re_r  <= s_re_nxt;
    s1_s_im_r  <= s_im_nxt;
  end

  // ---------------- stage 2
  always_comb begin
    den_sum = s1_p_brr_r + s1_p_bii_r;
    case (s1_kind_r)
      KIND_MUL: begin
        x_re_nxt = XW'(s1_p_rr_r) - XW'(s1_p_ii_r);
        x_im_nxt = XW'(s1_p_ri_r) + XW'(s1_p_ir_r);
      end
      KIND_DIV: begin
        x_re_nxt = XW'(s1_p_rr_r) + XW'(s1_p_ii_r);
        x_im_nxt = XW'(s1_p_ir_r) - XW'(s1_p_ri_r);
      end
      default: begin
        x_re_nxt = XW'(s1_s_re_r);
        x_im_nxt = XW'(s1_s_im_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind_r <= s1_kind_r;
    s2_x_re_r <= x_re_nxt;
    s2_x_im_r <= x_im_nxt;
    s2_den_r  <= den_sum;
  end

  // ---------------- stage 3
  always_comb begin
    sh_re    = (s2_kind_r == KIND_MUL) ? (s2_x_re_r >>> FRAC_BITS) : s2_x_re_r;
    sh_im    = (s2_kind_r == KIND_MUL) ? (s2_x_im_r >>> FRAC_BITS) : s2_x_im_r;
    sat_re   = sat_w(sh_re);
    sat_im   = sat_w(sh_im);
    neg_x_re = -s2_x_re_r;
    neg_x_im = -s2_x_im_r;
    mag_re_nxt = s2_x_re_r[XW-1] ? neg_x_re[PW-1:0] : s2_x_re_r[PW-1:0];
    mag_im_nxt = s2_x_im_r[XW-1] ? neg_x_im[PW-1:0] : s2_x_im_r[PW-1:0];

    s3_ctl_nxt        = '0;
    s3_ctl_nxt.valid  = s2_vld_r;
    s3_ctl_nxt.neg_re = s2_x_re_r[XW-1];
    s3_ctl_nxt.neg_im = s2_x_im_r[XW-1];
    if (s2_kind_r == KIND_DIV) begin
      // quotient bits are filled in by the divider; zero divisor gives zero
      q3_re_nxt = '0;
      q3_im_nxt = '0;
      if (s2_den_r == '0) begin
        s3_ctl_nxt.dz = 1'b1;
      end else begin
        s3_ctl_nxt.is_div = 1'b1;
      end
    end else begin
      q3_re_nxt     = sat_re[W-1:0];
      q3_im_nxt     = sat_im[W-1:0];
      s3_ctl_nxt.ov = sat_re[W] | sat_im[W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else begin
      s3_ctl_r <= s3_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s3_mag_re_r <= mag_re_nxt;
    s3_mag_im_r <= mag_im_nxt;
    s3_q_re_r   <= q3_re_nxt;
    s3_q_im_r   <= q3_im_nxt;
    s3_den_r    <= s2_den_r;
  end

  // ---------------- stage 4: quotient of W bits or saturation
  always_comb begin
    rem_re_nxt = RW'(s3_mag_re_r) << FRAC_BITS;
    rem_im_nxt = RW'(s3_mag_im_r) << FRAC_BITS;
    den_top    = RW'(s3_den_r) << W;
    s4_ctl_nxt = s3_ctl_r;
    s4_ctl_nxt.big_re = s3_ctl_r.is_div & (rem_re_nxt >= den_top);
    s4_ctl_nxt.big_im = s3_ctl_r.is_div & (rem_im_nxt >= den_top);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else begin
      s4_ctl_r <= s4_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s4_rem_re_r <= rem_re_nxt;
    s4_rem_im_r <= rem_im_nxt;
    s4_q_re_r   <= s3_q_re_r;
    s4_q_im_r   <= s3_q_im_r;
    s4_den_r    <= s3_den_r;
  end

  assign dv_ctl[0]    = s4_ctl_r;
  assign dv_rem_re[0] = s4_rem_re_r;
  assign dv_rem_im[0] = s4_rem_im_r;
  assign dv_q_re[0]   = s4_q_re_r;
  assign dv_q_im[0]   = s4_q_im_r;
  assign dv_den[0]    = s4_den_r;

  for (genvar g = 0; g < W; g++) begin : g_div
    cfa_div_step #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .STEP      (W-1-g)
    ) u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_ctl     (dv_ctl[g]),
      .in_rem_re  (dv_rem_re[g]),
      .in_rem_im  (dv_rem_im[g]),
      .in_q_re    (dv_q_re[g]),
      .in_q_im    (dv_q_im[g]),
      .in_den     (dv_den[g]),
      .out_ctl    (dv_ctl[g+1]),
      .out_rem_re (dv_rem_re[g+1]),
      .out_rem_im (dv_rem_im[g+1]),
      .out_q_re   (dv_q_re[g+1]),
      .out_q_im   (dv_q_im[g+1]),
      .out_den    (dv_den[g+1])
    );
  end

  // ---------------- final saturation of quotients
  always_comb begin
    neg_q_re = -dv_q_re[W];
    neg_q_im = -dv_q_im[W];
    sat_d_re = 1'b0;
    sat_d_im = 1'b0;
    f_re_nxt = dv_q_re[W];
    f_im_nxt = dv_q_im[W];
    if (dv_ctl[W].is_div) begin
      if (dv_ctl[W].neg_re) begin
        sat_d_re = dv_ctl[W].big_re | (dv_q_re[W] > W_MIN);
        f_re_nxt = sat_d_re ? W_MIN : neg_q_re;
      end else begin
        sat_d_re = dv_ctl[W].big_re | dv_q_re[W][W-1];
        f_re_nxt = sat_d_re ? W_MAX : dv_q_re[W];
      end
      if (dv_ctl[W].neg_im) begin
        sat_d_im = dv_ctl[W].big_im | (dv_q_im[W] > W_MIN);
        f_im_nxt = sat_d_im ? W_MIN : neg_q_im;
      end else begin
        sat_d_im = dv_ctl[W].big_im | dv_q_im[W][W-1];
        f_im_nxt = sat_d_im ? W_MAX : dv_q_im[W];
      end
    end
    f_ov_nxt = dv_ctl[W].ov | sat_d_re | sat_d_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= dv_ctl[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    f1_re_r <= f_re_nxt;
    f1_im_r <= f_im_nxt;
    f1_dz_r <= dv_ctl[W].dz;
    f1_ov_r <= f_ov_nxt;
  end

  // ---------------- class and output register
  always_comb begin
    mag_o_re   = f1_re_r[W-1] ? -f1_re_r : f1_re_r;
    mag_o_im   = f1_im_r[W-1] ? -f1_im_r : f1_im_r;
    cls_nxt[0] = CW'(mag_o_re) >= CW'(thr_r);
    cls_nxt[1] = CW'(mag_o_im) >= CW'(thr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_res_real     <= f1_re_r;
    out_res_imag     <= f1_im_r;
    out_result_class <= cls_nxt;
    out_div_zero     <= f1_dz_r;
    out_overflow     <= f1_ov_r;
  end

  a_dz_no_ov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> !out_overflow)
    else $error("divide by zero item also flagged overflow");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_res_real == '0 && out_res_imag == '0)
    else $error("divide by zero item has nonzero result");

  a_ov_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      out_res_real == W_MAX || out_res_real == W_MIN ||
      out_res_imag == W_MAX || out_res_imag == W_MIN)
    else $error("overflow flagged without a saturated part");

endmodule

// ----- src/cfa_div_step.sv -----
// cfa_div_step: one registered restoring-division step for both result parts
// depends on cfa_pkg; quotient bit STEP is decided here, others pass through
module cfa_div_step #(
  parameter int WORD_BITS = cfa_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cfa_pkg::FRAC_BITS_DEF,
  parameter int STEP      = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cfa_pkg::cfa_ctl_t                     in_ctl,
  input  logic [3*WORD_BITS+FRAC_BITS-1:0]      in_rem_re,
  input  logic [3*WORD_BITS+FRAC_BITS-1:0]      in_rem_im,
  input  logic [WORD_BITS-1:0]                  in_q_re,
  input  logic [WORD_BITS-1:0]                  in_q_im,
  input  logic [2*WORD_BITS-1:0]                in_den,
  output cfa_pkg::cfa_ctl_t                     out_ctl,
  output logic [3*WORD_BITS+FRAC_BITS-1:0]      out_rem_re,
  output logic [3*WORD_BITS+FRAC_BITS-1:0]      out_rem_im,
  output logic [WORD_BITS-1:0]                  out_q_re,
  output logic [WORD_BITS-1:0]                  out_q_im,
  output logic [2*WORD_BITS-1:0]                out_den
);
  import cfa_pkg::*;

  localparam int RW = 3*WORD_BITS+FRAC_BITS;

  logic [RW-1:0]        d_sh;
  logic                 ge_re, ge_im;
  logic [RW-1:0]        rem_re_nxt, rem_im_nxt;
  logic [WORD_BITS-1:0] q_re_nxt, q_im_nxt;

  cfa_ctl_t             ctl_r;
  logic [RW-1:0]        rem_re_r, rem_im_r;
  logic [WORD_BITS-1:0] q_re_r, q_im_r;
  logic [2*WORD_BITS-1:0] den_r;

  always_comb begin
    d_sh       = RW'(in_den) << STEP;
    ge_re      = in_rem_re >= d_sh;
    ge_im      = in_rem_im >= d_sh;
    rem_re_nxt = in_rem_re;
    rem_im_nxt = in_rem_im;
    q_re_nxt   = in_q_re;
    q_im_nxt   = in_q_im;
    // non-divide items carry their finished result in the quotient fields
    if (in_ctl.is_div) begin
      q_re_nxt[STEP] = ge_re;
      q_im_nxt[STEP] = ge_im;
      if (ge_re) begin
        rem_re_nxt = in_rem_re - d_sh;
      end
      if (ge_im) begin
        rem_im_nxt = in_rem_im - d_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    rem_re_r <= rem_re_nxt;
    rem_im_r <= rem_im_nxt;
    q_re_r   <= q_re_nxt;
    q_im_r   <= q_im_nxt;
    den_r    <= in_den;
  end

  assign out_ctl    = ctl_r;
  assign out_rem_re = rem_re_r;
  assign out_rem_im = rem_im_r;
  assign out_q_re   = q_re_r;
  assign out_q_im   = q_im_r;
  assign out_den    = den_r;

endmodule
